### rtl/core/tsub_pkg.sv
// ----------------------------------------------------------------------------
// tsub_pkg
// Shared types and codes of the thumb subtract execute unit: request and
// result words, the decoded operation word and the register file ports.
// ----------------------------------------------------------------------------
package tsub_pkg;

    localparam int TSUB_QUEUE_DEPTH = 2;
    localparam int NUM_REGS         = 16;
    localparam int REG_IDX_W        = 4;
    localparam int DATA_W           = 32;

    localparam logic [1:0] REQ_EXEC       = 2'd0;
    localparam logic [1:0] REQ_LOAD_REG   = 2'd1;
    localparam logic [1:0] REQ_LOAD_FLAGS = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_REG = 2'd1;
    localparam logic [1:0] STATUS_PC_DEST = 2'd2;
    localparam logic [1:0] STATUS_NOT_SUB = 2'd3;

    localparam logic [1:0] SHIFT_LSL = 2'd0;
    localparam logic [1:0] SHIFT_LSR = 2'd1;
    localparam logic [1:0] SHIFT_ASR = 2'd2;
    localparam logic [1:0] SHIFT_ROR = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_SP = 4'd13;
    localparam logic [REG_IDX_W-1:0] REG_PC = 4'd15;

    typedef enum logic [1:0] {
        KIND_EXEC,
        KIND_LOAD_REG,
        KIND_LOAD_FLAGS,
        KIND_NONE
    } tsub_kind_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] instruction;
        logic        is_wide;
        logic        in_it_block;
        logic [3:0]  reg_index;
        logic [31:0] load_value;
    } tsub_req_t;

    typedef struct packed {
        logic [3:0]  dest_index;
        logic [31:0] dest_value;
        logic        dest_written;
        logic [3:0]  flags_nzcv;
        logic        flags_written;
        logic [1:0]  status;
    } tsub_rsp_t;

    typedef struct packed {
        tsub_kind_t           kind;
        logic [1:0]           status;
        logic [REG_IDX_W-1:0] ra;
        logic [REG_IDX_W-1:0] rb;
        logic [REG_IDX_W-1:0] dest;
        logic [DATA_W-1:0]    imm;
        logic                 use_imm;
        logic [1:0]           shift_type;
        logic [4:0]           shift_amt;
        logic                 reverse;
        logic                 carry_from_flag;
        logic                 setf;
    } tsub_op_t;

    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr_a;
        logic [REG_IDX_W-1:0] addr_b;
    } tsub_rf_rd_t;

    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr;
        logic [DATA_W-1:0]    data;
    } tsub_rf_wr_t;

endpackage

### rtl/core/tsub_front.sv
// ----------------------------------------------------------------------------
// tsub_front
// Classifies each request word: decodes narrow and wide subtract encodings,
// checks registers, expands immediates and builds the operation word.
// ----------------------------------------------------------------------------
module tsub_front
    import tsub_pkg::*;
(
    input  tsub_req_t req,
    output tsub_op_t  op
);

    localparam logic [15:0] MASK_SBC  = 16'hffc0;
    localparam logic [15:0] MATCH_SBC = 16'h4180;
    localparam logic [15:0] MASK_SUB3 = 16'hfe00;
    localparam logic [15:0] MATCH_SUB3 = 16'h1e00;
    localparam logic [15:0] MASK_SUB8 = 16'hf800;
    localparam logic [15:0] MATCH_SUB8 = 16'h3800;
    localparam logic [15:0] MASK_SUBR = 16'hfe00;
    localparam logic [15:0] MATCH_SUBR = 16'h1a00;
    localparam logic [15:0] MASK_SUBSP = 16'hff80;
    localparam logic [15:0] MATCH_SUBSP = 16'hb080;
    localparam logic [31:0] MASK_W_IMM = 32'hfbe08000;
    localparam logic [31:0] MATCH_W_IMM = 32'hf1a00000;
    localparam logic [31:0] MASK_W_REG = 32'hffe08000;
    localparam logic [31:0] MATCH_W_SUB = 32'heba00000;
    localparam logic [31:0] MATCH_W_RSB = 32'hebc00000;

    function automatic logic [31:0] thumb_expand_imm(input logic [11:0] imm12);
        logic [31:0] imm8;
        logic [31:0] base;
        logic [63:0] dbl;
        logic [31:0] res;
        imm8 = {24'd0, imm12[7:0]};
        base = {24'd0, 1'b1, imm12[6:0]};
        dbl  = {base, base} >> imm12[11:7];
        res  = dbl[31:0];
        if (imm12[11:10] == 2'b00)
        begin
            case (imm12[9:8])
                2'd0: res = imm8;
                2'd1: res = (imm8 << 16) | imm8;
                2'd2: res = (imm8 << 24) | (imm8 << 8);
                default: res = (imm8 << 24) | (imm8 << 16) | (imm8 << 8) | imm8;
            endcase
        end
        return res;
    endfunction

    logic [15:0] h;
    logic [2:0]  r0;
    logic [2:0]  r3;
    logic [2:0]  r6;
    logic [3:0]  rn;
    logic [3:0]  rm;
    logic [3:0]  rd;
    logic        s_bit;
    logic        is_imm;
    logic        is_sub;
    logic        is_rsb;
    logic        bad_sub;
    logic        bad_rsb;
    logic [11:0] imm12;

    assign h      = req.instruction[15:0];
    assign r0     = h[2:0];
    assign r3     = h[5:3];
    assign r6     = h[8:6];
    assign rn     = req.instruction[19:16];
    assign rm     = req.instruction[3:0];
    assign rd     = req.instruction[11:8];
    assign s_bit  = req.instruction[20];
    assign is_imm = (req.instruction & MASK_W_IMM) == MATCH_W_IMM;
    assign is_sub = (req.instruction & MASK_W_REG) == MATCH_W_SUB;
    assign is_rsb = (req.instruction & MASK_W_REG) == MATCH_W_RSB;
    assign imm12  = {req.instruction[26], req.instruction[14:12], req.instruction[7:0]};

    assign bad_sub = (rd == REG_SP) || ((rd == REG_PC) && !s_bit) || (rn == REG_PC)
                     || (is_sub && ((rm == REG_SP) || (rm == REG_PC)));
    assign bad_rsb = (rd == REG_SP) || (rd == REG_PC) || (rn == REG_SP) || (rn == REG_PC)
                     || (rm == REG_SP) || (rm == REG_PC);

    always_comb
    begin
        op                 = '0;
        op.kind            = KIND_NONE;
        op.status          = STATUS_NOT_SUB;
        op.shift_type      = SHIFT_LSL;
        case (req.req_type)
            REQ_LOAD_REG:
            begin
                op.kind   = KIND_LOAD_REG;
                op.status = STATUS_OK;
                op.dest   = req.reg_index;
                op.imm    = req.load_value;
            end
            REQ_LOAD_FLAGS:
            begin
                op.kind   = KIND_LOAD_FLAGS;
                op.status = STATUS_OK;
                op.imm    = req.load_value;
            end
            REQ_EXEC:
            begin
                if (!req.is_wide)
                begin
                    if ((h & MASK_SBC) == MATCH_SBC)
                    begin
                        op.kind            = KIND_EXEC;
                        op.status          = STATUS_OK;
                        op.ra              = {1'b0, r0};
                        op.rb              = {1'b0, r3};
                        op.dest            = {1'b0, r0};
                        op.carry_from_flag = 1'b1;
                        op.setf            = !req.in_it_block;
                    end
                    else if ((h & MASK_SUB3) == MATCH_SUB3)
                    begin
                        op.kind    = KIND_EXEC;
                        op.status  = STATUS_OK;
                        op.ra      = {1'b0, r3};
                        op.dest    = {1'b0, r0};
                        op.imm     = {29'd0, r6};
                        op.use_imm = 1'b1;
                        op.setf    = !req.in_it_block;
                    end
                    else if ((h & MASK_SUB8) == MATCH_SUB8)
                    begin
                        op.kind    = KIND_EXEC;
                        op.status  = STATUS_OK;
                        op.ra      = {1'b0, h[10:8]};
                        op.dest    = {1'b0, h[10:8]};
                        op.imm     = {24'd0, h[7:0]};
                        op.use_imm = 1'b1;
                        op.setf    = !req.in_it_block;
                    end
                    else if ((h & MASK_SUBR) == MATCH_SUBR)
                    begin
                        op.kind   = KIND_EXEC;
                        op.status = STATUS_OK;
                        op.ra     = {1'b0, r3};
                        op.rb     = {1'b0, r6};
                        op.dest   = {1'b0, r0};
                        op.setf   = !req.in_it_block;
                    end
                    else if ((h & MASK_SUBSP) == MATCH_SUBSP)
                    begin
                        op.kind    = KIND_EXEC;
                        op.status  = STATUS_OK;
                        op.ra      = REG_SP;
                        op.dest    = REG_SP;
                        op.imm     = {23'd0, h[6:0], 2'b00};
                        op.use_imm = 1'b1;
                    end
                end
                else
                begin
                    if ((is_imm || is_sub) && (((rd == REG_PC) && s_bit) || (rn == REG_SP)))
                    begin
                        op.status = STATUS_NOT_SUB;
                    end
                    else if ((is_imm || is_sub) && bad_sub)
                    begin
                        op.status = STATUS_BAD_REG;
                    end
                    else if (is_rsb && bad_rsb)
                    begin
                        op.status = STATUS_BAD_REG;
                    end
                    else if (!(is_imm || is_sub || is_rsb))
                    begin
                        op.status = STATUS_NOT_SUB;
                    end
                    else if (rd == REG_PC)
                    begin
                        op.status = STATUS_PC_DEST;
                    end
                    else
                    begin
                        op.kind       = KIND_EXEC;
                        op.status     = STATUS_OK;
                        op.ra         = rn;
                        op.rb         = rm;
                        op.dest       = rd;
                        op.imm        = thumb_expand_imm(imm12);
                        op.use_imm    = is_imm;
                        op.shift_type = req.instruction[5:4];
                        op.shift_amt  = {req.instruction[14:12], req.instruction[7:6]};
                        op.reverse    = is_rsb;
                        op.setf       = s_bit;
                    end
                end
            end
            default:
            begin
                op.kind   = KIND_NONE;
                op.status = STATUS_NOT_SUB;
            end
        endcase
    end

endmodule

### rtl/core/tsub_queue.sv
// ----------------------------------------------------------------------------
// tsub_queue
// Short first-in first-out queue of decoded operation words between the
// front and the back.
// ----------------------------------------------------------------------------
module tsub_queue
    import tsub_pkg::*;
#(
    parameter int DEPTH = TSUB_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  tsub_op_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output tsub_op_t pop_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tsub_op_t             entry_reg [DEPTH];
    logic [IDX_W-1:0]     wr_ptr_reg;
    logic [IDX_W-1:0]     wr_ptr_next;
    logic [IDX_W-1:0]     rd_ptr_reg;
    logic [IDX_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/tsub_regfile.sv
// ----------------------------------------------------------------------------
// tsub_regfile
// Sixteen-entry register file with two registered read ports, one write
// port, write-first bypass and per-entry valid bits cleared at reset.
// ----------------------------------------------------------------------------
module tsub_regfile
    import tsub_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tsub_rf_rd_t       rd,
    input  tsub_rf_wr_t       wr,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0]   mem [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [DATA_W-1:0]   rd_data_a_reg;
    logic [DATA_W-1:0]   rd_data_b_reg;

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            if (wr.en && (wr.addr == rd.addr_a))
                rd_data_a_reg <= wr.data;
            else
                rd_data_a_reg <= valid_reg[rd.addr_a] ? mem[rd.addr_a] : '0;
            if (wr.en && (wr.addr == rd.addr_b))
                rd_data_b_reg <= wr.data;
            else
                rd_data_b_reg <= valid_reg[rd.addr_b] ? mem[rd.addr_b] : '0;
        end
    end

endmodule

### rtl/core/tsub_back.sv
// ----------------------------------------------------------------------------
// tsub_back
// Issue and execute: reads operands, applies the shift, computes the
// subtract with carry, updates registers and flags and holds the result word.
// ----------------------------------------------------------------------------
module tsub_back
    import tsub_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_valid,
    output logic      op_ready,
    input  tsub_op_t  op_data,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output tsub_rsp_t rsp_data
);

    function automatic logic [31:0] imm_shift(input logic [31:0] v, input logic [1:0] kind,
                                              input logic [4:0] amt, input logic cin);
        logic [63:0] dbl;
        logic [31:0] res;
        dbl = {v, v} >> amt;
        res = v;
        case (kind)
            SHIFT_LSL: res = v << amt;
            SHIFT_LSR: res = (amt == 5'd0) ? 32'd0 : (v >> amt);
            SHIFT_ASR: res = (amt == 5'd0) ? {32{v[31]}} : 32'($signed(v) >>> amt);
            default:   res = (amt == 5'd0) ? {cin, v[31:1]} : dbl[31:0];
        endcase
        return res;
    endfunction

    tsub_op_t          ex_op_reg;
    logic              ex_valid_reg;
    logic              ex_valid_next;
    logic              ex_fire;
    logic              issue;
    logic [3:0]        flags_reg;
    logic [3:0]        flags_next;
    logic              flags_we;
    tsub_rsp_t         out_reg;
    tsub_rsp_t         out_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    tsub_rf_rd_t       rf_rd;
    tsub_rf_wr_t       rf_wr;
    logic [DATA_W-1:0] val_a;
    logic [DATA_W-1:0] val_b;
    logic [DATA_W-1:0] shifted;
    logic [DATA_W-1:0] opx;
    logic [DATA_W-1:0] opy;
    logic [DATA_W-1:0] not_y;
    logic              cin;
    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] res;
    logic [3:0]        nzcv;

    assign ex_fire  = ex_valid_reg && (!out_valid_reg || rsp_ready);
    assign op_ready = !ex_valid_reg || ex_fire;
    assign issue    = op_valid && op_ready;

    assign rf_rd.en     = issue;
    assign rf_rd.addr_a = op_data.ra;
    assign rf_rd.addr_b = op_data.rb;

    tsub_regfile u_regfile
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd        (rf_rd),
        .wr        (rf_wr),
        .rd_data_a (val_a),
        .rd_data_b (val_b)
    );

    assign shifted = imm_shift(val_b, ex_op_reg.shift_type, ex_op_reg.shift_amt, flags_reg[1]);
    assign opx     = ex_op_reg.reverse ? shifted : val_a;
    assign opy     = ex_op_reg.reverse ? val_a : (ex_op_reg.use_imm ? ex_op_reg.imm : shifted);
    assign not_y   = ~opy;
    assign cin     = ex_op_reg.carry_from_flag ? flags_reg[1] : 1'b1;
    assign sum     = {1'b0, opx} + {1'b0, not_y} + {{DATA_W{1'b0}}, cin};
    assign res     = sum[DATA_W-1:0];
    assign nzcv    = {res[31], res == '0, sum[DATA_W],
                      (opx[31] == not_y[31]) && (res[31] != opx[31])};

    always_comb
    begin
        rf_wr          = '0;
        flags_we       = 1'b0;
        flags_next     = flags_reg;
        out_next       = '0;
        out_next.status = ex_op_reg.status;
        case (ex_op_reg.kind)
            KIND_EXEC:
            begin
                rf_wr.en      = ex_fire;
                rf_wr.addr    = ex_op_reg.dest;
                rf_wr.data    = res;
                flags_we      = ex_op_reg.setf;
                flags_next    = ex_op_reg.setf ? nzcv : flags_reg;
                out_next.dest_index   = ex_op_reg.dest;
                out_next.dest_value   = res;
                out_next.dest_written = 1'b1;
            end
            KIND_LOAD_REG:
            begin
                rf_wr.en      = ex_fire;
                rf_wr.addr    = ex_op_reg.dest;
                rf_wr.data    = ex_op_reg.imm;
                out_next.dest_index   = ex_op_reg.dest;
                out_next.dest_value   = ex_op_reg.imm;
                out_next.dest_written = 1'b1;
            end
            KIND_LOAD_FLAGS:
            begin
                flags_we   = 1'b1;
                flags_next = ex_op_reg.imm[3:0];
            end
            default:
            begin
                flags_we = 1'b0;
            end
        endcase
        out_next.flags_nzcv    = flags_next;
        out_next.flags_written = flags_we;
    end

    always_comb
    begin
        ex_valid_next = ex_valid_reg;
        if (issue)
            ex_valid_next = 1'b1;
        else if (ex_fire)
            ex_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (ex_fire)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            ex_valid_reg  <= ex_valid_next;
            out_valid_reg <= out_valid_next;
            if (ex_fire && flags_we)
                flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
            ex_op_reg <= op_data;
        if (ex_fire)
            out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ex_fire |=> $stable(flags_reg))
        else $error("flags changed without a retiring word");

    a_issue_slot: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (!ex_valid_reg || ex_fire))
        else $error("issue into an occupied execute slot");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp_ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("result word lost while stalled");

    a_ex_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ex_valid_reg && !ex_fire) |=> ex_valid_reg)
        else $error("execute word dropped while stalled");
`endif

endmodule

### rtl/core/thumb_subtract_execute_unit_top.sv
// ----------------------------------------------------------------------------
// thumb_subtract_execute_unit_top
// Executes the thumb subtract family against a local register file and flags.
// ----------------------------------------------------------------------------
// usage
//   req channel: req_valid / req_ready / req_data carry one request word:
//   execute an instruction, load a register or load the flags
//   rsp channel: rsp_valid / rsp_ready / rsp_data return exactly one result
//   word per request, in order
//   path: a request is decoded into the queue, its operands are read as it
//   enters the execute slot, and the result is registered in the output reg
//   throughput: one word per cycle unless stalled, set by the single execute
//   stage; register file reads are registered and bypassed from the write port
//   stall: while rsp_ready is low the result is held, the execute slot fills,
//   then the queue fills and req_ready drops
//   reset: rst_n clears all registers to zero, the flags to zero and empties
//   the queue and pipeline; no clearing pass is needed
// ----------------------------------------------------------------------------
module thumb_subtract_execute_unit_top
    import tsub_pkg::*;
#(
    parameter int QUEUE_DEPTH = TSUB_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  tsub_req_t req_data,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output tsub_rsp_t rsp_data
);

    tsub_op_t dec_op;
    tsub_op_t q_op;
    logic     q_valid;
    logic     q_ready;

    tsub_front u_front
    (
        .req (req_data),
        .op  (dec_op)
    );

    tsub_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (req_valid),
        .push_ready (req_ready),
        .push_data  (dec_op),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_op)
    );

    tsub_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (q_valid),
        .op_ready  (q_ready),
        .op_data   (q_op),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

### tb/sv/thumb_subtract_execute_unit_top_tb.sv
// ----------------------------------------------------------------------------
// thumb_subtract_execute_unit_top_tb
// Self-checking bench for the thumb subtract execute unit. A local model of the
// register file and NZCV flags predicts one response word per request word.
// A short directed table covers the encodings, bad-register and compare forms,
// shift and immediate corners. Random traffic follows with bursty requests, a
// stalling receiver, one long receiver hold and one full drain.
// ----------------------------------------------------------------------------
module thumb_subtract_execute_unit_top_tb;
    import tsub_pkg::*;

    localparam logic [1:0]  REQ_UNKNOWN  = 2'd3;

    localparam logic [15:0] NMSK_SBC     = 16'hFFC0;
    localparam logic [15:0] NOPC_SBC     = 16'h4180;
    localparam logic [15:0] NMSK_SUB3    = 16'hFE00;
    localparam logic [15:0] NOPC_SUB3    = 16'h1E00;
    localparam logic [15:0] NMSK_SUB8    = 16'hF800;
    localparam logic [15:0] NOPC_SUB8    = 16'h3800;
    localparam logic [15:0] NMSK_SUBR    = 16'hFE00;
    localparam logic [15:0] NOPC_SUBR    = 16'h1A00;
    localparam logic [15:0] NMSK_SUBSP   = 16'hFF80;
    localparam logic [15:0] NOPC_SUBSP   = 16'hB080;
    localparam logic [31:0] WMSK_IMM     = 32'hFBE08000;
    localparam logic [31:0] WOPC_SUB_IMM = 32'hF1A00000;
    localparam logic [31:0] WMSK_REG     = 32'hFFE08000;
    localparam logic [31:0] WOPC_SUB_REG = 32'hEBA00000;
    localparam logic [31:0] WOPC_RSB_REG = 32'hEBC00000;

    localparam int RAND_WORDS   = 1900;
    localparam int HOLD_CYCLES  = 150;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        tsub_req_t word;
        bit        typed;
        tsub_rsp_t want;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    tsub_req_t req_data;
    logic      rsp_valid;
    logic      rsp_ready;
    tsub_rsp_t rsp_data;

    logic [31:0] gpr [16];
    logic [3:0]  apsr_nzcv;
    tsub_rsp_t   pending_rsp [$];
    stim_row_t   dir_rows [$];
    int          err_count;
    int          cycle_count;
    int          burst_left;
    bit          ready_hold_req;

    thumb_subtract_execute_unit_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] sub_carry(input logic [31:0] x, input logic [31:0] y,
                                              input logic cin, output logic [3:0] f);
        logic [32:0] sum;
        logic [31:0] ny;
        ny  = ~y;
        sum = {1'b0, x} + {1'b0, ny} + {32'b0, cin};
        f   = {sum[31], sum[31:0] == 32'd0, sum[32],
               (x[31] == ny[31]) && (sum[31] != x[31])};
        return sum[31:0];
    endfunction

    function automatic logic [31:0] shift_operand(input logic [31:0] v, input logic [1:0] sh,
                                                  input logic [4:0] amt, input logic cin);
        case (sh)
            SHIFT_LSL: return v << amt;
            SHIFT_LSR: return (amt == 5'd0) ? 32'd0 : v >> amt;
            SHIFT_ASR: return (amt == 5'd0) ? {32{v[31]}} : 32'($signed(v) >>> amt);
            default:   return (amt == 5'd0) ? {cin, v[31:1]} : (v >> amt) | (v << (32 - amt));
        endcase
    endfunction

    function automatic logic [31:0] expand_imm12(input logic [11:0] i);
        logic [7:0]  b;
        logic [31:0] base;
        logic [4:0]  rot;
        b = i[7:0];
        if (i[11:10] == 2'd0)
        begin
            case (i[9:8])
                2'd0:    return {24'd0, b};
                2'd1:    return {8'd0, b, 8'd0, b};
                2'd2:    return {b, 8'd0, b, 8'd0};
                default: return {b, b, b, b};
            endcase
        end
        base = {24'd0, 1'b1, i[6:0]};
        rot  = i[11:7];
        return (base >> rot) | (base << (32 - rot));
    endfunction

    function automatic tsub_rsp_t exec_subtract(input tsub_req_t w);
        tsub_rsp_t   r;
        logic [15:0] h;
        logic [31:0] inst;
        logic [31:0] val;
        logic [31:0] opnd;
        logic [3:0]  rd;
        logic [3:0]  rn;
        logic [3:0]  rm;
        logic [3:0]  f;
        logic [4:0]  amt;
        logic        cin;
        logic        setf;
        logic        s;
        logic        is_imm;
        logic        is_sub;
        logic        is_rsb;
        logic        bad;
        logic        run;
        r        = '0;
        r.status = STATUS_NOT_SUB;
        val      = '0;
        f        = '0;
        rd       = '0;
        setf     = 1'b0;
        run      = 1'b0;
        cin      = apsr_nzcv[1];
        inst     = w.instruction;
        h        = inst[15:0];
        if (w.req_type == REQ_LOAD_REG)
        begin
            gpr[w.reg_index] = w.load_value;
            r.dest_index     = w.reg_index;
            r.dest_value     = w.load_value;
            r.dest_written   = 1'b1;
            r.status         = STATUS_OK;
        end
        else if (w.req_type == REQ_LOAD_FLAGS)
        begin
            apsr_nzcv       = w.load_value[3:0];
            r.flags_written = 1'b1;
            r.status        = STATUS_OK;
        end
        else if (w.req_type == REQ_EXEC && !w.is_wide)
        begin
            run  = 1'b1;
            setf = !w.in_it_block;
            rd   = {1'b0, h[2:0]};
            if ((h & NMSK_SBC) == NOPC_SBC)
                val = sub_carry(gpr[h[2:0]], gpr[h[5:3]], cin, f);
            else if ((h & NMSK_SUB3) == NOPC_SUB3)
                val = sub_carry(gpr[h[5:3]], 32'(h[8:6]), 1'b1, f);
            else if ((h & NMSK_SUB8) == NOPC_SUB8)
            begin
                rd  = {1'b0, h[10:8]};
                val = sub_carry(gpr[h[10:8]], 32'(h[7:0]), 1'b1, f);
            end
            else if ((h & NMSK_SUBR) == NOPC_SUBR)
                val = sub_carry(gpr[h[5:3]], gpr[h[8:6]], 1'b1, f);
            else if ((h & NMSK_SUBSP) == NOPC_SUBSP)
            begin
                rd   = REG_SP;
                setf = 1'b0;
                val  = sub_carry(gpr[REG_SP], {23'd0, h[6:0], 2'b00}, 1'b1, f);
            end
            else
                run = 1'b0;
        end
        else if (w.req_type == REQ_EXEC)
        begin
            rn     = inst[19:16];
            rm     = inst[3:0];
            rd     = inst[11:8];
            s      = inst[20];
            amt    = {inst[14:12], inst[7:6]};
            is_imm = (inst & WMSK_IMM) == WOPC_SUB_IMM;
            is_sub = (inst & WMSK_REG) == WOPC_SUB_REG;
            is_rsb = (inst & WMSK_REG) == WOPC_RSB_REG;
            bad    = (rd == REG_SP) || (rd == REG_PC && !s) || (rn == REG_PC);
            // compare and sp forms belong to other units
            if ((is_imm || is_sub) && !((rd == REG_PC && s) || rn == REG_SP))
            begin
                if (bad || (is_sub && (rm == REG_SP || rm == REG_PC)))
                    r.status = STATUS_BAD_REG;
                else
                    run = 1'b1;
            end
            else if (is_rsb)
            begin
                if (rd == REG_SP || rd == REG_PC || rn == REG_SP || rn == REG_PC ||
                    rm == REG_SP || rm == REG_PC)
                    r.status = STATUS_BAD_REG;
                else
                    run = 1'b1;
            end
            if (run && rd == REG_PC)
            begin
                r.status = STATUS_PC_DEST;
                run      = 1'b0;
            end
            if (run)
            begin
                setf = s;
                if (is_imm)
                    val = sub_carry(gpr[rn], expand_imm12({inst[26], inst[14:12], inst[7:0]}),
                                    1'b1, f);
                else
                begin
                    opnd = shift_operand(gpr[rm], inst[5:4], amt, cin);
                    if (is_sub)
                        val = sub_carry(gpr[rn], opnd, 1'b1, f);
                    else
                        val = sub_carry(opnd, gpr[rn], 1'b1, f);
                end
            end
        end
        if (run)
        begin
            gpr[rd] = val;
            if (setf)
                apsr_nzcv = f;
            r.dest_index    = rd;
            r.dest_value    = val;
            r.dest_written  = 1'b1;
            r.flags_written = setf;
            r.status        = STATUS_OK;
        end
        r.flags_nzcv = apsr_nzcv;
        return r;
    endfunction

    function automatic logic [31:0] enc_wimm(input logic i, input logic s, input logic [3:0] rn,
                                             input logic [2:0] imm3, input logic [3:0] rd,
                                             input logic [7:0] imm8);
        return WOPC_SUB_IMM | {5'd0, i, 5'd0, s, rn, 1'b0, imm3, rd, imm8};
    endfunction

    function automatic logic [31:0] enc_wreg(input logic [31:0] opc, input logic s,
                                             input logic [3:0] rn, input logic [2:0] imm3,
                                             input logic [3:0] rd, input logic [1:0] imm2,
                                             input logic [1:0] sh, input logic [3:0] rm);
        return opc | {11'd0, s, rn, 1'b0, imm3, rd, imm2, sh, rm};
    endfunction

    function automatic tsub_req_t mk_req(input logic [1:0] kind, input logic [31:0] inst,
                                         input logic wide, input logic it,
                                         input logic [3:0] idx, input logic [31:0] val);
        tsub_req_t w;
        w.req_type    = kind;
        w.instruction = inst;
        w.is_wide     = wide;
        w.in_it_block = it;
        w.reg_index   = idx;
        w.load_value  = val;
        return w;
    endfunction

    function automatic tsub_rsp_t mk_rsp(input logic [3:0] di, input logic [31:0] dv,
                                         input logic dw, input logic [3:0] nzcv,
                                         input logic fw, input logic [1:0] st);
        tsub_rsp_t r;
        r.dest_index    = di;
        r.dest_value    = dv;
        r.dest_written  = dw;
        r.flags_nzcv    = nzcv;
        r.flags_written = fw;
        r.status        = st;
        return r;
    endfunction

    function automatic void add_row(input tsub_req_t w, input bit typed, input tsub_rsp_t want);
        stim_row_t row;
        row.word  = w;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [3:0] pick_reg();
        logic [3:0] r;
        r = 4'($urandom_range(0, 15));
        if ((r == REG_SP || r == REG_PC) && $urandom_range(0, 3) != 0)
            r = 4'($urandom_range(0, 12));
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'($urandom_range(0, 300));
            default: return $urandom();
        endcase
    endfunction

    function automatic tsub_req_t random_word();
        tsub_req_t   w;
        logic [31:0] raw;
        int          sel;
        raw = $urandom();
        sel = $urandom_range(0, 99);
        w   = mk_req(REQ_EXEC, $urandom(), 1'b0, 1'($urandom_range(0, 1)),
                     4'($urandom_range(0, 15)), pick_value());
        if (sel < 12)
            w.req_type = REQ_LOAD_REG;
        else if (sel < 16)
            w.req_type = REQ_LOAD_FLAGS;
        else if (sel < 18)
            w.req_type = REQ_UNKNOWN;
        else if (sel < 55)
        begin
            case ($urandom_range(0, 5))
                0: w.instruction[15:0] = NOPC_SBC | (raw[15:0] & ~NMSK_SBC);
                1: w.instruction[15:0] = NOPC_SUB3 | (raw[15:0] & ~NMSK_SUB3);
                2: w.instruction[15:0] = NOPC_SUB8 | (raw[15:0] & ~NMSK_SUB8);
                3: w.instruction[15:0] = NOPC_SUBR | (raw[15:0] & ~NMSK_SUBR);
                4: w.instruction[15:0] = NOPC_SUBSP | (raw[15:0] & ~NMSK_SUBSP);
                default: ;
            endcase
        end
        else
        begin
            w.is_wide = 1'b1;
            case ($urandom_range(0, 6))
                0, 1: w.instruction = enc_wimm(raw[26], raw[20], pick_reg(), raw[14:12],
                                               pick_reg(), raw[7:0]);
                2, 3: w.instruction = enc_wreg(WOPC_SUB_REG, raw[20], pick_reg(), raw[14:12],
                                               pick_reg(), raw[7:6], raw[5:4], pick_reg());
                4, 5: w.instruction = enc_wreg(WOPC_RSB_REG, raw[20], pick_reg(), raw[14:12],
                                               pick_reg(), raw[7:6], raw[5:4], pick_reg());
                default: ;
            endcase
        end
        return w;
    endfunction

    task automatic send_word(input tsub_req_t w, input bit typed, input tsub_rsp_t want);
        tsub_rsp_t pred;
        int        gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req_data  <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pred = exec_subtract(w);
        pending_rsp.push_back(typed ? want : pred);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        burst_left = 0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge clk)
    begin : rsp_check
        tsub_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response word with nothing outstanding: %h", rsp_data);
                err_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("dest_index", 32'(want.dest_index), 32'(rsp_data.dest_index));
                check_field("dest_value", want.dest_value, rsp_data.dest_value);
                check_field("dest_written", 32'(want.dest_written), 32'(rsp_data.dest_written));
                check_field("flags_nzcv", 32'(want.flags_nzcv), 32'(rsp_data.flags_nzcv));
                check_field("flags_written", 32'(want.flags_written),
                            32'(rsp_data.flags_written));
                check_field("status", 32'(want.status), 32'(rsp_data.status));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver pacing: full rate, random, mostly-ready and mostly-stalled stretches
    initial
    begin : rsp_pacer
        int mode;
        int span;
        int k;
        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 48);
            for (k = 0; k < span && !ready_hold_req; k++)
            begin
                case (mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ready <= ($urandom_range(0, 4) != 0);
                    default: rsp_ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge clk);
            end
            if (ready_hold_req)
            begin
                ready_hold_req = 1'b0;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int n;
        rst_n          <= 1'b0;
        req_valid      <= 1'b0;
        req_data       <= '0;
        err_count      = 0;
        burst_left     = 0;
        ready_hold_req = 1'b0;
        apsr_nzcv      = 4'h0;
        foreach (gpr[i])
            gpr[i] = 32'd0;

        // rows checked against fixed values, all taken with flags known
        add_row(mk_req(REQ_EXEC, 32'h0000_1EC8, 1'b0, 1'b0, 4'd0, 32'd0), 1'b1,
                mk_rsp(4'd0, 32'hFFFF_FFFD, 1'b1, 4'b1000, 1'b1, STATUS_OK));
        add_row(mk_req(REQ_LOAD_FLAGS, 32'd0, 1'b0, 1'b0, 4'd0, 32'hFFFF_FFFF), 1'b1,
                mk_rsp(4'd0, 32'd0, 1'b0, 4'hF, 1'b1, STATUS_OK));
        add_row(mk_req(REQ_UNKNOWN, 32'hFFFF_FFFF, 1'b1, 1'b1, 4'hF, 32'hFFFF_FFFF), 1'b1,
                mk_rsp(4'd0, 32'd0, 1'b0, 4'hF, 1'b0, STATUS_NOT_SUB));
        add_row(mk_req(REQ_EXEC, enc_wimm(1'b0, 1'b1, 4'd1, 3'd0, REG_PC, 8'd1),
                       1'b1, 1'b0, 4'd0, 32'd0), 1'b1,
                mk_rsp(4'd0, 32'd0, 1'b0, 4'hF, 1'b0, STATUS_NOT_SUB));
        add_row(mk_req(REQ_EXEC, enc_wreg(WOPC_SUB_REG, 1'b0, REG_SP, 3'd0, 4'd2, 2'd0,
                                          SHIFT_LSL, 4'd3), 1'b1, 1'b0, 4'd0, 32'd0), 1'b1,
                mk_rsp(4'd0, 32'd0, 1'b0, 4'hF, 1'b0, STATUS_NOT_SUB));
        add_row(mk_req(REQ_EXEC, enc_wimm(1'b0, 1'b0, 4'd1, 3'd0, REG_SP, 8'd5),
                       1'b1, 1'b0, 4'd0, 32'd0), 1'b1,
                mk_rsp(4'd0, 32'd0, 1'b0, 4'hF, 1'b0, STATUS_BAD_REG));
        add_row(mk_req(REQ_EXEC, enc_wimm(1'b0, 1'b0, 4'd1, 3'd0, REG_PC, 8'd5),
                       1'b1, 1'b0, 4'd0, 32'd0), 1'b1,
                mk_rsp(4'd0, 32'd0, 1'b0, 4'hF, 1'b0, STATUS_BAD_REG));
        add_row(mk_req(REQ_EXEC, enc_wimm(1'b0, 1'b1, REG_PC, 3'd0, 4'd1, 8'd5),
                       1'b1, 1'b0, 4'd0, 32'd0), 1'b1,
                mk_rsp(4'd0, 32'd0, 1'b0, 4'hF, 1'b0, STATUS_BAD_REG));
        add_row(mk_req(REQ_EXEC, enc_wreg(WOPC_SUB_REG, 1'b1, 4'd1, 3'd0, 4'd2, 2'd0,
                                          SHIFT_LSL, REG_SP), 1'b1, 1'b0, 4'd0, 32'd0), 1'b1,
                mk_rsp(4'd0, 32'd0, 1'b0, 4'hF, 1'b0, STATUS_BAD_REG));
        add_row(mk_req(REQ_EXEC, enc_wreg(WOPC_RSB_REG, 1'b1, 4'd1, 3'd0, REG_PC, 2'd0,
                                          SHIFT_LSL, 4'd2), 1'b1, 1'b0, 4'd0, 32'd0), 1'b1,
                mk_rsp(4'd0, 32'd0, 1'b0, 4'hF, 1'b0, STATUS_BAD_REG));
        add_row(mk_req(REQ_EXEC, enc_wreg(WOPC_RSB_REG, 1'b0, REG_SP, 3'd0, 4'd1, 2'd0,
                                          SHIFT_LSL, 4'd2), 1'b1, 1'b0, 4'd0, 32'd0), 1'b1,
                mk_rsp(4'd0, 32'd0, 1'b0, 4'hF, 1'b0, STATUS_BAD_REG));
        add_row(mk_req(REQ_EXEC, 32'hFFFF_FFFF, 1'b1, 1'b1, 4'd0, 32'd0), 1'b1,
                mk_rsp(4'd0, 32'd0, 1'b0, 4'hF, 1'b0, STATUS_NOT_SUB));
        add_row(mk_req(REQ_EXEC, 32'hFFFF_1C00, 1'b0, 1'b0, 4'd0, 32'd0), 1'b1,
                mk_rsp(4'd0, 32'd0, 1'b0, 4'hF, 1'b0, STATUS_NOT_SUB));
        add_row(mk_req(REQ_LOAD_REG, 32'd0, 1'b0, 1'b0, 4'd1, 32'hFFFF_FFFF), 1'b1,
                mk_rsp(4'd1, 32'hFFFF_FFFF, 1'b1, 4'hF, 1'b0, STATUS_OK));
        add_row(mk_req(REQ_LOAD_REG, 32'd0, 1'b0, 1'b0, 4'd2, 32'h8000_0000), 1'b1,
                mk_rsp(4'd2, 32'h8000_0000, 1'b1, 4'hF, 1'b0, STATUS_OK));
        add_row(mk_req(REQ_LOAD_REG, 32'd0, 1'b0, 1'b0, 4'd3, 32'h7FFF_FFFF), 1'b1,
                mk_rsp(4'd3, 32'h7FFF_FFFF, 1'b1, 4'hF, 1'b0, STATUS_OK));
        add_row(mk_req(REQ_LOAD_REG, 32'd0, 1'b0, 1'b0, REG_SP, 32'h0000_1000), 1'b1,
                mk_rsp(REG_SP, 32'h0000_1000, 1'b1, 4'hF, 1'b0, STATUS_OK));

        // rows left to the predictor
        add_row(mk_req(REQ_EXEC, 32'hABCD_419A, 1'b0, 1'b0, 4'd0, 32'd0), 1'b0, '0);
        add_row(mk_req(REQ_EXEC, 32'h0000_3BFF, 1'b0, 1'b1, 4'd0, 32'd0), 1'b0, '0);
        add_row(mk_req(REQ_EXEC, 32'h0000_1A4C, 1'b0, 1'b0, 4'd0, 32'd0), 1'b0, '0);
        add_row(mk_req(REQ_EXEC, 32'h0000_B0FF, 1'b0, 1'b0, 4'd0, 32'd0), 1'b0, '0);
        add_row(mk_req(REQ_EXEC, enc_wimm(1'b0, 1'b1, 4'd2, 3'd3, 4'd5, 8'd0),
                       1'b1, 1'b1, 4'd0, 32'd0), 1'b0, '0);
        add_row(mk_req(REQ_EXEC, enc_wimm(1'b1, 1'b1, 4'd3, 3'd7, 4'd6, 8'hFF),
                       1'b1, 1'b0, 4'd0, 32'd0), 1'b0, '0);
        add_row(mk_req(REQ_EXEC, enc_wreg(WOPC_SUB_REG, 1'b1, 4'd1, 3'd0, 4'd7, 2'd0,
                                          SHIFT_ASR, 4'd2), 1'b1, 1'b0, 4'd0, 32'd0), 1'b0, '0);
        add_row(mk_req(REQ_EXEC, enc_wreg(WOPC_SUB_REG, 1'b0, 4'd3, 3'd0, 4'd8, 2'd0,
                                          SHIFT_ROR, 4'd1), 1'b1, 1'b0, 4'd0, 32'd0), 1'b0, '0);
        add_row(mk_req(REQ_EXEC, enc_wreg(WOPC_RSB_REG, 1'b1, 4'd2, 3'd0, 4'd9, 2'd0,
                                          SHIFT_LSR, 4'd3), 1'b1, 1'b0, 4'd0, 32'd0), 1'b0, '0);
        add_row(mk_req(REQ_EXEC, enc_wreg(WOPC_RSB_REG, 1'b1, 4'd2, 3'd7, 4'd10, 2'd3,
                                          SHIFT_LSL, 4'd1), 1'b1, 1'b0, 4'd0, 32'd0), 1'b0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);

        for (n = 0; n < RAND_WORDS; n++)
        begin
            if (n == 600)
                ready_hold_req = 1'b1;
            if (n == 1200)
                wait_drained();
            send_word(random_word(), 1'b0, '0);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/core/tsub_pkg.sv
rtl/core/tsub_front.sv
rtl/core/tsub_queue.sv
rtl/core/tsub_regfile.sv
rtl/core/tsub_back.sv
rtl/core/thumb_subtract_execute_unit_top.sv
tb/sv/thumb_subtract_execute_unit_top_tb.sv
